/* rtl/first_occurrence_filter_defines.svh */
// assertion macros shared by the first occurrence filter rtl
`ifndef FIRST_OCCURRENCE_FILTER_DEFINES_SVH
`define FIRST_OCCURRENCE_FILTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fo_pkg.sv */
// types and constants of the first occurrence filter
`timescale 1ns / 1ps
package fo_pkg;

  localparam int VTYPE_BITS = 2;
  localparam int ROW_BITS   = 8;
  localparam int COUNT_BITS = 9;
  localparam int EXT_BITS   = 64;

  localparam logic [VTYPE_BITS-1:0] VT_BOOL  = 2'd0;
  localparam logic [VTYPE_BITS-1:0] VT_INT   = 2'd1;
  localparam logic [VTYPE_BITS-1:0] VT_FLOAT = 2'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [30:0] FLOAT_INF_MAG = 31'h7F80_0000;

  typedef logic [VTYPE_BITS-1:0] vtype_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // control token travelling along the cell chain
  typedef struct packed {
    logic   valid;
    logic   last;
    logic   hit;
    logic   ins;
    row_t   row;
    count_t count;
  } tok_t;

endpackage

/* rtl/fo_if.sv */
// valid/ready stream interfaces for input and result transfers
`timescale 1ns / 1ps
interface fo_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  end_of_column;

  modport source (output valid, output value, output end_of_column, input ready);
  modport sink   (input valid, input value, input end_of_column, output ready);
endinterface

interface fo_out_if;
  logic                       valid;
  logic                       ready;
  logic                       is_unique;
  logic [fo_pkg::ROW_BITS-1:0]   row_index;
  logic [fo_pkg::COUNT_BITS-1:0] distinct_count;
  logic                       overflow;
  logic                       is_last;

  modport source (output valid, output is_unique, output row_index,
                  output distinct_count, output overflow, output is_last, input ready);
  modport sink   (input valid, input is_unique, input row_index,
                  input distinct_count, input overflow, input is_last, output ready);
endinterface

/* rtl/fo_cell.sv */
// one store cell of the chain: holds one distinct value and passes the token on
`timescale 1ns / 1ps
module fo_cell #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  fo_pkg::vtype_t        vtype,
  input  fo_pkg::tok_t          tok_in,
  input  logic [VALUE_BITS-1:0] val_in,
  output fo_pkg::tok_t          tok_out,
  output logic [VALUE_BITS-1:0] val_out
);

  fo_pkg::tok_t          tok_r, tok_nxt;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] store_r, store_nxt;
  logic                  store_valid_r, store_valid_nxt;
  logic                  eq;
  logic                  ins;

  function automatic logic values_equal(input logic [VALUE_BITS-1:0] a,
                                        input logic [VALUE_BITS-1:0] b,
                                        input fo_pkg::vtype_t t);
    logic [fo_pkg::EXT_BITS-1:0] ax;
    logic [fo_pkg::EXT_BITS-1:0] bx;
    logic                        nan_a;
    logic                        nan_b;
    logic                        zeros;
    logic                        res;
    ax    = fo_pkg::EXT_BITS'(a);
    bx    = fo_pkg::EXT_BITS'(b);
    nan_a = ax[30:0] > fo_pkg::FLOAT_INF_MAG;
    nan_b = bx[30:0] > fo_pkg::FLOAT_INF_MAG;
    zeros = (ax[30:0] == '0) && (bx[30:0] == '0);
    case (t)
      fo_pkg::VT_BOOL:  res = (a[0] == b[0]);
      fo_pkg::VT_FLOAT: res = !nan_a && !nan_b && (zeros || (ax[31:0] == bx[31:0]));
      default:          res = (a == b);
    endcase
    return res;
  endfunction

  always_comb begin
    eq  = store_valid_r && values_equal(store_r, val_in, vtype);
    ins = tok_in.valid && !tok_in.hit && !tok_in.ins && !store_valid_r;

    tok_nxt = tok_in;
    if (tok_in.valid) begin
      tok_nxt.hit = tok_in.hit | eq;
      tok_nxt.ins = tok_in.ins | ins;
      if ((store_valid_r || ins) && (tok_in.count != fo_pkg::COUNT_MAX)) begin
        tok_nxt.count = tok_in.count + 1'b1;
      end
    end

    store_valid_nxt = store_valid_r;
    if (tok_in.valid && tok_in.last) begin
      store_valid_nxt = 1'b0;
    end else if (ins) begin
      store_valid_nxt = 1'b1;
    end
    store_nxt = ins ? val_in : store_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r         <= '0;
      store_valid_r <= 1'b0;
    end else if (advance) begin
      tok_r         <= tok_nxt;
      store_valid_r <= store_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      val_r   <= val_in;
      store_r <= store_nxt;
    end
  end

  assign tok_out = tok_r;
  assign val_out = val_r;

endmodule

/* rtl/first_occurrence_filter.sv */
// Streaming first-occurrence filter for one column of values.
// in_chan carries value and end_of_column; a transfer happens when valid and
// ready are both high. out_chan returns one result per input row: is_unique,
// row_index, distinct_count, overflow and is_last, in input order.
// cfg_we/cfg_wdata write the comparison rule (0 bool, 1 integer, 2 float);
// write it only while no rows are in flight.
// Each row walks a chain of MAX_DISTINCT store cells, one cell per cycle while
// the chain advances, and then lands in the output register.
// The chain is fully pipelined, so one row is taken every cycle unless the
// receiver stalls; the cell chain length sets the latency and the single output register the rate.
// New values fill the first free cell a row reaches; the row behind sees it.
// A row marked end_of_column empties each cell as it passes, so the next
// column starts with an empty store without any dead cycles.
// Reset empties the store, clears the row counter and selects the integer rule.
// When the receiver stalls, the whole chain holds and in_chan.ready drops
// until the waiting result is taken.
`timescale 1ns / 1ps
`include "first_occurrence_filter_defines.svh"
module first_occurrence_filter #(
  parameter int MAX_DISTINCT = 256,
  parameter int VALUE_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  fo_in_if.sink               in_chan,
  fo_out_if.source            out_chan,
  input  logic                cfg_we,
  input  fo_pkg::vtype_t      cfg_wdata
);

  logic                  advance;
  logic                  in_xfer;
  fo_pkg::vtype_t        vtype_r;
  fo_pkg::row_t          row_r, row_nxt;
  fo_pkg::tok_t          tok   [0:MAX_DISTINCT];
  logic [VALUE_BITS-1:0] val   [0:MAX_DISTINCT];
  fo_pkg::tok_t          tail;

  logic                  out_valid_r;
  logic                  out_unique_r;
  fo_pkg::row_t          out_row_r;
  fo_pkg::count_t        out_count_r;
  logic                  out_overflow_r;
  logic                  out_last_r;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance;
  assign in_xfer       = in_chan.valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtype_r <= fo_pkg::VT_INT;
    end else if (cfg_we) begin
      vtype_r <= cfg_wdata;
    end
  end

  always_comb begin
    row_nxt = row_r;
    if (in_xfer) begin
      row_nxt = in_chan.end_of_column ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_xfer;
    tok[0].last  = in_chan.end_of_column;
    tok[0].row   = row_r;
    val[0]       = in_chan.value;
  end

  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    fo_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .vtype   (vtype_r),
      .tok_in  (tok[i]),
      .val_in  (val[i]),
      .tok_out (tok[i+1]),
      .val_out (val[i+1])
    );
  end

  assign tail = tok[MAX_DISTINCT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_unique_r   <= !tail.hit;
      out_row_r      <= tail.row;
      out_count_r    <= tail.count;
      out_overflow_r <= !tail.hit && !tail.ins;
      out_last_r     <= tail.last;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.is_unique      = out_unique_r;
  assign out_chan.row_index      = out_row_r;
  assign out_chan.distinct_count = out_count_r;
  assign out_chan.overflow       = out_overflow_r;
  assign out_chan.is_last        = out_last_r;

  // overflow only ever accompanies a new value
  `FO_ASSERT_NOW(a_ovf_unique, clk, rst_n, out_valid_r && out_overflow_r, out_unique_r, "overflow on a repeated value")
  // a repeated value means something is already stored
  `FO_ASSERT_NOW(a_dup_count, clk, rst_n, out_valid_r && !out_unique_r, out_count_r != '0, "repeat with empty store")
  // the row counter moves only with an input transfer
  `FO_ASSERT_NEXT(a_row_hold, clk, rst_n, !in_xfer, $stable(row_r), "row counter moved without transfer")
  // the last row of a column restarts the row count
  `FO_ASSERT_NEXT(a_row_clear, clk, rst_n, in_xfer && in_chan.end_of_column, row_r == '0, "row counter not cleared after last row")

endmodule
